[rtl/ups_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package ups_pkg;

  localparam int MAX_WIDTH  = 1024;
  localparam int MAX_SCALE  = 4;
  localparam int PIXEL_BITS = 16;
  localparam int LIMIT_DIM  = 1024;

  localparam int COL_W      = $clog2(MAX_WIDTH);
  localparam int DIM_W      = $clog2(LIMIT_DIM);
  localparam int COORD_W    = 12;
  localparam int SCALE_W    = 3;
  localparam int OFS_W      = 2;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 11;

  // result queue between the arithmetic pipe and the output port
  localparam int FIFO_DEPTH = 8;
  localparam int FIFO_AW    = $clog2(FIFO_DEPTH);
  localparam int FIFO_CW    = FIFO_AW + 2;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_MODE     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SCALE    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_WIDTH    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_HEIGHT   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_CHANNELS = 3'd4;

  // output blocks an item can complete, in emission order
  localparam logic [1:0] BLK_UL   = 2'd0;  // block at (r-1, c-1)
  localparam logic [1:0] BLK_UP   = 2'd1;  // block at (r-1, c)
  localparam logic [1:0] BLK_LEFT = 2'd2;  // block at (r, c-1)
  localparam logic [1:0] BLK_HERE = 2'd3;  // block at (r, c)

  // floor(t/9) = (t * RECIP9) >> RECIP_SHIFT, exact for t < 2**21
  localparam logic [20:0] RECIP9      = 21'd1864136;
  localparam int          RECIP_SHIFT = 24;

  typedef logic [PIXEL_BITS-1:0] pixel_t;

  typedef struct packed {
    logic             load;
    logic             issue;
    logic [1:0]       blk;
    logic [OFS_W-1:0] a;
    logic [OFS_W-1:0] b;
    logic             last;
    logic             commit;
  } cmd_t;

  typedef struct packed {
    logic             room;
    logic             bilinear;
    logic             first_row;
    logic             first_col;
    logic             last_row;
    logic             last_col;
    logic [OFS_W-1:0] s_last;
  } status_t;

  typedef struct packed {
    logic [DIM_W-1:0]   plane;
    logic [COORD_W-1:0] row;
    logic [COORD_W-1:0] col;
    logic               last;
  } tag_t;

  typedef struct packed {
    tag_t   tag;
    pixel_t pixel;
  } out_item_t;

  function automatic logic [1:0] first_blk(input logic [3:0] mask);
    logic [1:0] blk;
    priority if (mask[BLK_UL])   blk = BLK_UL;
    else if     (mask[BLK_UP])   blk = BLK_UP;
    else if     (mask[BLK_LEFT]) blk = BLK_LEFT;
    else                         blk = BLK_HERE;
    return blk;
  endfunction

  // last valid index of a dimension register: 0 acts as 1, above hi acts as hi
  function automatic logic [CFG_DATA_W-1:0] clamp_last(input logic [CFG_DATA_W-1:0] v,
                                                       input logic [CFG_DATA_W-1:0] hi);
    logic [CFG_DATA_W-1:0] r;
    priority if (v == '0) r = '0;
    else if     (v > hi)  r = hi - 1'b1;
    else                  r = v - 1'b1;
    return r;
  endfunction

endpackage

`default_nettype wire

[rtl/ups_ctrl.sv]
`timescale 1ns / 1ps
`default_nettype none

module ups_ctrl import ups_pkg::*; (
  input  wire logic    clk,
  input  wire logic    rst,
  input  wire logic    in_valid,
  output logic         in_stall,
  input  wire status_t status,
  output cmd_t         cmd
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_LOAD = 2'd1;
  localparam logic [1:0] S_EMIT = 2'd2;
  localparam logic [1:0] S_FIN  = 2'd3;

  logic [1:0]       state, state_next;
  logic [3:0]       mask, mask_next;
  logic [1:0]       blk, blk_next;
  logic [OFS_W-1:0] a, a_next;
  logic [OFS_W-1:0] b, b_next;
  logic [3:0]       load_mask;
  logic [3:0]       rest;
  logic             a_end, b_end;

  always_comb begin
    if (!status.bilinear) begin
      load_mask = '0;
      load_mask[BLK_HERE] = 1'b1;
    end else begin
      load_mask[BLK_UL]   = !status.first_row && !status.first_col;
      load_mask[BLK_UP]   = !status.first_row && status.last_col;
      load_mask[BLK_LEFT] = status.last_row && !status.first_col;
      load_mask[BLK_HERE] = status.last_row && status.last_col;
    end
  end

  assign rest  = mask & ~(4'b0001 << blk);
  assign a_end = (a == status.s_last);
  assign b_end = (b == status.s_last);

  always_comb begin
    state_next = state;
    mask_next  = mask;
    blk_next   = blk;
    a_next     = a;
    b_next     = b;
    cmd        = '0;
    cmd.blk    = blk;
    cmd.a      = a;
    cmd.b      = b;
    cmd.last   = a_end && b_end && (rest == '0);
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = S_LOAD;
        end
      end
      S_LOAD: begin
        mask_next  = load_mask;
        blk_next   = first_blk(load_mask);
        a_next     = '0;
        b_next     = '0;
        state_next = (load_mask == '0) ? S_FIN : S_EMIT;
      end
      S_EMIT: begin
        if (status.room) begin
          cmd.issue = 1'b1;
          if (b_end) begin
            b_next = '0;
            if (a_end) begin
              a_next    = '0;
              mask_next = rest;
              if (rest == '0) state_next = S_FIN;
              else blk_next = first_blk(rest);
            end else begin
              a_next = a + 1'b1;
            end
          end else begin
            b_next = b + 1'b1;
          end
        end
      end
      S_FIN: begin
        cmd.commit = 1'b1;
        state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      mask  <= '0;
      blk   <= BLK_UL;
      a     <= '0;
      b     <= '0;
    end else begin
      state <= state_next;
      mask  <= mask_next;
      blk   <= blk_next;
      a     <= a_next;
      b     <= b_next;
    end
  end

  assign in_stall = (state != S_IDLE);

  a_emit_mask: assert property (@(posedge clk) disable iff (rst)
    state == S_EMIT |-> mask != 4'b0000)
    else $error("emitting with no block pending");

  a_last_fin: assert property (@(posedge clk) disable iff (rst)
    cmd.issue && cmd.last |=> state == S_FIN)
    else $error("last result issued but item not finished");

endmodule

`default_nettype wire

[rtl/ups_datapath.sv]
`timescale 1ns / 1ps
`default_nettype none

module ups_datapath import ups_pkg::*; (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  cfg_we,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data,
  input  wire logic [PIXEL_BITS-1:0] pixel_in,
  input  wire cmd_t                  cmd,
  output status_t                    status,
  output logic                       out_valid,
  input  wire logic                  out_stall,
  output logic [DIM_W-1:0]           plane,
  output logic [COORD_W-1:0]         out_row,
  output logic [COORD_W-1:0]         out_col,
  output logic [PIXEL_BITS-1:0]      pixel_out,
  output logic                       run_end
);

  localparam int PROD_W = PIXEL_BITS + 5;
  localparam int T_W    = PIXEL_BITS + 4;

  // configuration
  logic                  mode_bilinear;
  logic [SCALE_W-1:0]    scale;
  logic [CFG_DATA_W-1:0] in_width, in_height, channel_count;
  logic                  cfg_hit;
  logic [SCALE_W-1:0]    s_eff;
  logic [COL_W-1:0]      w_last;
  logic [DIM_W-1:0]      h_last, ch_last;
  logic [4:0]            s2;
  logic [3:0]            half;

  // stream state
  pixel_t           line_store [MAX_WIDTH];
  pixel_t           cur, above, left_pixel, upper_left_pixel;
  logic [COL_W-1:0] col_count;
  logic [DIM_W-1:0] row_count, plane_count;

  always_ff @(posedge clk) begin
    if (rst) begin
      mode_bilinear <= 1'b0;
      scale         <= 3'd2;
      in_width      <= CFG_DATA_W'(MAX_WIDTH);
      in_height     <= CFG_DATA_W'(LIMIT_DIM);
      channel_count <= CFG_DATA_W'(1);
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_MODE:     mode_bilinear <= cfg_data[0];
        REG_SCALE:    scale         <= cfg_data[SCALE_W-1:0];
        REG_WIDTH:    in_width      <= cfg_data;
        REG_HEIGHT:   in_height     <= cfg_data;
        REG_CHANNELS: channel_count <= cfg_data;
        default: ;
      endcase
    end
  end

  assign cfg_hit = cfg_we && (cfg_index == REG_MODE || cfg_index == REG_SCALE ||
                              cfg_index == REG_WIDTH || cfg_index == REG_HEIGHT ||
                              cfg_index == REG_CHANNELS);

  always_comb begin
    priority if (scale == '0)                     s_eff = SCALE_W'(1);
    else if     (scale > SCALE_W'(MAX_SCALE))     s_eff = SCALE_W'(MAX_SCALE);
    else                                          s_eff = scale;
  end

  assign w_last  = COL_W'(clamp_last(in_width, CFG_DATA_W'(MAX_WIDTH)));
  assign h_last  = DIM_W'(clamp_last(in_height, CFG_DATA_W'(LIMIT_DIM)));
  assign ch_last = DIM_W'(clamp_last(channel_count, CFG_DATA_W'(LIMIT_DIM)));

  always_comb begin
    unique case (s_eff)
      3'd2:    begin s2 = 5'd4;  half = 4'd2; end
      3'd3:    begin s2 = 5'd9;  half = 4'd4; end
      3'd4:    begin s2 = 5'd16; half = 4'd8; end
      default: begin s2 = 5'd1;  half = 4'd0; end
    endcase
  end

  // line store: read on accept, written back when the item finishes
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      cur   <= pixel_in;
      above <= line_store[col_count];
    end
    if (cmd.commit) line_store[col_count] <= cur;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      left_pixel       <= '0;
      upper_left_pixel <= '0;
      col_count        <= '0;
      row_count        <= '0;
      plane_count      <= '0;
    end else if (cfg_hit) begin
      col_count   <= '0;
      row_count   <= '0;
      plane_count <= '0;
    end else if (cmd.commit) begin
      left_pixel       <= cur;
      upper_left_pixel <= above;
      if (col_count == w_last) begin
        col_count <= '0;
        if (row_count == h_last) begin
          row_count   <= '0;
          plane_count <= (plane_count == ch_last) ? '0 : plane_count + 1'b1;
        end else begin
          row_count <= row_count + 1'b1;
        end
      end else begin
        col_count <= col_count + 1'b1;
      end
    end
  end

  // stage A: corners, weights, coordinates
  pixel_t           tl, tr, bl, bra;
  logic [DIM_W-1:0] blk_row;
  logic [COL_W-1:0] blk_col;
  logic [SCALE_W-1:0] wa0, wb0;

  always_comb begin
    unique case (cmd.blk)
      BLK_UL: begin
        tl = upper_left_pixel; tr = above; bl = left_pixel; bra = cur;
        blk_row = row_count - 1'b1; blk_col = col_count - 1'b1;
      end
      BLK_UP: begin
        tl = above; tr = above; bl = cur; bra = cur;
        blk_row = row_count - 1'b1; blk_col = col_count;
      end
      BLK_LEFT: begin
        tl = left_pixel; tr = cur; bl = left_pixel; bra = cur;
        blk_row = row_count; blk_col = col_count - 1'b1;
      end
      default: begin
        tl = cur; tr = cur; bl = cur; bra = cur;
        blk_row = row_count; blk_col = col_count;
      end
    endcase
  end

  assign wa0 = s_eff - {1'b0, cmd.a};
  assign wb0 = s_eff - {1'b0, cmd.b};

  logic         va;
  logic [4:0]   wa [4];
  pixel_t       pa [4];
  tag_t         tag_a;

  always_ff @(posedge clk) begin
    if (rst) va <= 1'b0;
    else     va <= cmd.issue;
  end

  always_ff @(posedge clk) begin
    if (cmd.issue) begin
      wa[0] <= {2'b0, wa0} * {2'b0, wb0};
      wa[1] <= {2'b0, wa0} * {3'b0, cmd.b};
      wa[2] <= {3'b0, cmd.a} * {2'b0, wb0};
      wa[3] <= {3'b0, cmd.a} * {3'b0, cmd.b};
      pa[0] <= tl;
      pa[1] <= tr;
      pa[2] <= bl;
      pa[3] <= bra;
      tag_a.plane <= plane_count;
      tag_a.row   <= ({{(COORD_W-DIM_W){1'b0}}, blk_row} *
                      {{(COORD_W-SCALE_W){1'b0}}, s_eff}) +
                     {{(COORD_W-OFS_W){1'b0}}, cmd.a};
      tag_a.col   <= ({{(COORD_W-COL_W){1'b0}}, blk_col} *
                      {{(COORD_W-SCALE_W){1'b0}}, s_eff}) +
                     {{(COORD_W-OFS_W){1'b0}}, cmd.b};
      tag_a.last  <= cmd.last;
    end
  end

  // stage B: weighted corners (two's complement, modulo PROD_W)
  logic              vb;
  logic [PROD_W-1:0] pb [4];
  tag_t              tag_b;

  always_ff @(posedge clk) begin
    if (rst) vb <= 1'b0;
    else     vb <= va;
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < 4; i++) begin
      pb[i] <= {{(PROD_W-PIXEL_BITS){pa[i][PIXEL_BITS-1]}}, pa[i]} *
               {{(PROD_W-5){1'b0}}, wa[i]};
    end
    tag_b <= tag_a;
  end

  // stage C: sum plus rounding and offset bias, always in [0, 2**T_W)
  logic           vc;
  logic [T_W-1:0] tc;
  tag_t           tag_c;

  always_ff @(posedge clk) begin
    if (rst) vc <= 1'b0;
    else     vc <= vb;
  end

  always_ff @(posedge clk) begin
    tc <= pb[0][T_W-1:0] + pb[1][T_W-1:0] + pb[2][T_W-1:0] + pb[3][T_W-1:0] +
          {s2, {(PIXEL_BITS-1){1'b0}}} + {{(T_W-4){1'b0}}, half};
    tag_c <= tag_b;
  end

  // stage D: divide by scale squared
  logic          vd;
  pixel_t        qd;
  tag_t          tag_d;
  logic [40:0]   recip_prod;

  assign recip_prod = {21'b0, tc} * {20'b0, RECIP9};

  always_ff @(posedge clk) begin
    if (rst) vd <= 1'b0;
    else     vd <= vc;
  end

  always_ff @(posedge clk) begin
    unique case (s_eff)
      3'd2:    qd <= tc[PIXEL_BITS+1:2];
      3'd3:    qd <= recip_prod[RECIP_SHIFT+PIXEL_BITS-1:RECIP_SHIFT];
      3'd4:    qd <= tc[PIXEL_BITS+3:4];
      default: qd <= tc[PIXEL_BITS-1:0];
    endcase
    tag_d <= tag_c;
  end

  // result queue; issue is gated so that it can never overflow
  out_item_t          fifo_mem [FIFO_DEPTH];
  logic [FIFO_AW-1:0] wptr, rptr;
  logic [FIFO_CW-1:0] fifo_count, occ;
  logic               pop;
  out_item_t          head;

  assign pop = out_valid && !out_stall;

  always_ff @(posedge clk) begin
    if (vd) begin
      fifo_mem[wptr].tag   <= tag_d;
      fifo_mem[wptr].pixel <= {~qd[PIXEL_BITS-1], qd[PIXEL_BITS-2:0]};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr       <= '0;
      rptr       <= '0;
      fifo_count <= '0;
    end else begin
      if (vd)  wptr <= wptr + 1'b1;
      if (pop) rptr <= rptr + 1'b1;
      fifo_count <= fifo_count + FIFO_CW'(vd) - FIFO_CW'(pop);
    end
  end

  assign occ = fifo_count + FIFO_CW'(va) + FIFO_CW'(vb) + FIFO_CW'(vc) + FIFO_CW'(vd);

  assign head      = fifo_mem[rptr];
  assign out_valid = (fifo_count != '0);
  assign plane     = head.tag.plane;
  assign out_row   = head.tag.row;
  assign out_col   = head.tag.col;
  assign run_end   = head.tag.last;
  assign pixel_out = head.pixel;

  always_comb begin
    status           = '0;
    status.room      = (occ < FIFO_CW'(FIFO_DEPTH));
    status.bilinear  = mode_bilinear;
    status.first_row = (row_count == '0);
    status.first_col = (col_count == '0);
    status.last_row  = (row_count == h_last);
    status.last_col  = (col_count == w_last);
    status.s_last    = OFS_W'(s_eff - 1'b1);
  end

  a_occ_bound: assert property (@(posedge clk) disable iff (rst)
    occ <= FIFO_CW'(FIFO_DEPTH))
    else $error("results in flight exceed queue depth");

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    vd && fifo_count == FIFO_CW'(FIFO_DEPTH) |-> pop)
    else $error("result queue overflow");

endmodule

`default_nettype wire

[rtl/image_upsampler_nearest_bilinear_core.sv]
// The block sequencer reads the line store when it accepts an item, then issues
//   its results into a four-stage multiply/divide pipe (stages A to D) and the
//   result queue, n blocks of scale*scale results per item (n = 1 in nearest mode,
//   0..4 in bilinear mode), one issued per cycle while the queue has room; it ends
//   the item with one line-store write-back.
// Reset (synchronous, active high): counters and edge pixels cleared, registers
//   at defaults; the line store is not cleared and needs no clearing pass.
`timescale 1ns / 1ps
`default_nettype none

module image_upsampler_nearest_bilinear_core import ups_pkg::*; (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  cfg_we,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data,
  input  wire logic                  in_valid,
  output logic                       in_stall,
  input  wire logic [PIXEL_BITS-1:0] pixel_in,
  output logic                       out_valid,
  input  wire logic                  out_stall,
  output logic [DIM_W-1:0]           plane,
  output logic [COORD_W-1:0]         out_row,
  output logic [COORD_W-1:0]         out_col,
  output logic [PIXEL_BITS-1:0]      pixel_out,
  output logic                       run_end
);

  cmd_t    cmd;
  status_t status;

  ups_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .status   (status),
    .cmd      (cmd)
  );

  ups_datapath u_dp (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .pixel_in  (pixel_in),
    .cmd       (cmd),
    .status    (status),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .plane     (plane),
    .out_row   (out_row),
    .out_col   (out_col),
    .pixel_out (pixel_out),
    .run_end   (run_end)
  );

endmodule

`default_nettype wire

[tb/ups_checker.sv]
`timescale 1ns / 1ps

module ups_checker import ups_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic                  in_valid,
  input  logic                  in_stall,
  input  logic [PIXEL_BITS-1:0] pixel_in,
  input  logic                  out_valid,
  input  logic                  out_stall,
  input  logic [DIM_W-1:0]      plane,
  input  logic [COORD_W-1:0]    out_row,
  input  logic [COORD_W-1:0]    out_col,
  input  logic [PIXEL_BITS-1:0] pixel_out,
  input  logic                  run_end,
  output int                    errors,
  output int                    pending,
  output int                    compared
);

  typedef struct packed {
    logic [DIM_W-1:0]   plane;
    logic [COORD_W-1:0] row;
    logic [COORD_W-1:0] col;
    pixel_t             pixel;
    logic               last;
  } out_px_t;

  localparam int Q_BIAS = 1 << (PIXEL_BITS - 1);

  out_px_t               due_px[$];
  int                    row_buf[MAX_WIDTH];
  int                    left_px;
  int                    upleft_px;
  int                    row_n;
  int                    col_n;
  int                    plane_n;
  logic                  bilinear;
  logic [SCALE_W-1:0]    scale_r;
  logic [CFG_DATA_W-1:0] width_r;
  logic [CFG_DATA_W-1:0] height_r;
  logic [CFG_DATA_W-1:0] chans_r;
  int                    err_n;
  int                    cmp_n;

  // zero acts as one, anything above the limit acts as the limit
  function automatic int eff_dim(input int v, input int hi);
    if (v == 0) return 1;
    return (v > hi) ? hi : v;
  endfunction

  // one scale x scale block from its four corners, raster order
  function automatic void push_block(input int s, input int br, input int bc,
                                     input int tl, input int tr, input int bl,
                                     input int brc);
    out_px_t e;
    int      a;
    int      b;
    int      s2;
    int      sum;
    s2 = s * s;
    for (a = 0; a < s; a++) begin
      for (b = 0; b < s; b++) begin
        sum = (s - a) * (s - b) * tl + (s - a) * b * tr + a * (s - b) * bl + a * b * brc;
        e.plane = plane_n[DIM_W-1:0];
        e.row   = COORD_W'(br * s + a);
        e.col   = COORD_W'(bc * s + b);
        // bias keeps the dividend positive so the division floors
        e.pixel = PIXEL_BITS'((sum + s2 / 2 + s2 * Q_BIAS) / s2 - Q_BIAS);
        e.last  = 1'b0;
        due_px.push_back(e);
      end
    end
  endfunction

  function automatic void upsample_step(input logic [PIXEL_BITS-1:0] raw);
    int s;
    int w;
    int h;
    int ch;
    int r;
    int c;
    int cur;
    int above;
    int n0;
    s     = eff_dim(int'(scale_r), MAX_SCALE);
    w     = eff_dim(int'(width_r), MAX_WIDTH);
    h     = eff_dim(int'(height_r), LIMIT_DIM);
    ch    = eff_dim(int'(chans_r), LIMIT_DIM);
    r     = row_n;
    c     = col_n;
    cur   = int'($signed(raw));
    above = row_buf[c];
    n0    = due_px.size();
    if (!bilinear) begin
      push_block(s, r, c, cur, cur, cur, cur);
    end else begin
      if (r >= 1) begin
        if (c >= 1) push_block(s, r - 1, c - 1, upleft_px, above, left_px, cur);
        if (c == w - 1) push_block(s, r - 1, c, above, above, cur, cur);
      end
      // bottom edge clamps to the current row
      if (r == h - 1) begin
        if (c >= 1) push_block(s, r, c - 1, left_px, cur, left_px, cur);
        if (c == w - 1) push_block(s, r, c, cur, cur, cur, cur);
      end
    end
    if (due_px.size() > n0) due_px[due_px.size() - 1].last = 1'b1;

    upleft_px  = above;
    row_buf[c] = cur;
    left_px    = cur;
    c++;
    if (c >= w) begin
      c = 0;
      r++;
      if (r >= h) begin
        r = 0;
        plane_n++;
        if (plane_n >= ch) plane_n = 0;
      end
    end
    col_n = c;
    row_n = r;
  endfunction

  always @(posedge clk) begin
    out_px_t want;
    if (rst) begin
      due_px.delete();
      foreach (row_buf[i]) row_buf[i] = 0;
      left_px   = 0;
      upleft_px = 0;
      row_n     = 0;
      col_n     = 0;
      plane_n   = 0;
      bilinear  = 1'b0;
      scale_r   = 3'd2;
      width_r   = 11'd1024;
      height_r  = 11'd1024;
      chans_r   = 11'd1;
      err_n     = 0;
      cmp_n     = 0;
    end else begin
      if (cfg_we && cfg_index <= REG_CHANNELS) begin
        case (cfg_index)
          REG_MODE:     bilinear = cfg_data[0];
          REG_SCALE:    scale_r  = cfg_data[SCALE_W-1:0];
          REG_WIDTH:    width_r  = cfg_data;
          REG_HEIGHT:   height_r = cfg_data;
          REG_CHANNELS: chans_r  = cfg_data;
          default: ;
        endcase
        // any register write restarts the stream
        row_n   = 0;
        col_n   = 0;
        plane_n = 0;
      end
      if (in_valid && !in_stall) upsample_step(pixel_in);
      if (out_valid && !out_stall) begin
        if (due_px.size() == 0) begin
          $error("output pixel with nothing due: plane %0d row %0d col %0d",
                 plane, out_row, out_col);
          err_n++;
        end else begin
          want = due_px.pop_front();
          cmp_n++;
          if (plane !== want.plane) begin
            $error("plane: expected %0d, got %0d", want.plane, plane);
            err_n++;
          end
          if (out_row !== want.row) begin
            $error("out_row: expected %0d, got %0d", want.row, out_row);
            err_n++;
          end
          if (out_col !== want.col) begin
            $error("out_col: expected %0d, got %0d", want.col, out_col);
            err_n++;
          end
          if (pixel_out !== want.pixel) begin
            $error("pixel_out: expected %0d, got %0d", $signed(want.pixel), $signed(pixel_out));
            err_n++;
          end
          if (run_end !== want.last) begin
            $error("run_end: expected %0d, got %0d", want.last, run_end);
            err_n++;
          end
        end
      end
    end
    errors   <= err_n;
    pending  <= due_px.size();
    compared <= cmp_n;
  end

endmodule

[tb/image_upsampler_nearest_bilinear_core_tb.sv]
`timescale 1ns / 1ps

module image_upsampler_nearest_bilinear_core_tb;
  import ups_pkg::*;

  localparam int LIMIT_CYCLES  = 500000;
  localparam int DRAIN_CYCLES  = 32;
  localparam int HOLD_CYCLES   = 400;
  localparam int RANDOM_PIXELS = 180;
  localparam int CFG_MAX       = (1 << CFG_DATA_W) - 1;
  localparam int SCALE_MAX_RAW = (1 << SCALE_W) - 1;

  // slots past the register list
  localparam logic [CFG_IDX_W-1:0] REG_SPARE     = REG_CHANNELS + 1'b1;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_TOP = '1;

  logic                  clk       = 1'b0;
  logic                  rst       = 1'b1;
  logic                  cfg_we    = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = REG_MODE;
  logic [CFG_DATA_W-1:0] cfg_data  = '0;
  logic                  in_valid  = 1'b0;
  logic                  in_stall;
  logic [PIXEL_BITS-1:0] pixel_in  = '0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  logic [DIM_W-1:0]      plane;
  logic [COORD_W-1:0]    out_row;
  logic [COORD_W-1:0]    out_col;
  logic [PIXEL_BITS-1:0] pixel_out;
  logic                  run_end;

  int   errors;
  int   pending;
  int   compared;
  int   sent       = 0;
  int   settings   = 0;
  int   burst_left = 0;
  int   cycle_n    = 0;
  logic hold_req   = 1'b0;
  logic hold_done  = 1'b0;
  int   hold_left  = 0;
  int   seg_left   = 0;
  int   stall_pct  = 0;

  image_upsampler_nearest_bilinear_core i_dut (.*);

  ups_checker i_check (.*);

  always #5 clk = ~clk;

  // output side: random stall segments, plus one long hold-off on request
  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      out_stall <= 1'b1;
    end else if (hold_req && !hold_done) begin
      hold_done <= 1'b1;
      hold_left <= HOLD_CYCLES;
      out_stall <= 1'b1;
    end else begin
      if (seg_left == 0) begin
        seg_left <= $urandom_range(4, 60);
        case ($urandom_range(0, 4))
          0, 1:    stall_pct <= 0;
          2:       stall_pct <= 25;
          3:       stall_pct <= 55;
          default: stall_pct <= 85;
        endcase
      end else begin
        seg_left <= seg_left - 1;
      end
      out_stall <= ($urandom_range(0, 99) < stall_pct);
    end
  end

  initial begin
    while (cycle_n < LIMIT_CYCLES) begin
      @(posedge clk);
      cycle_n++;
    end
    $display("simulation failed");
    $finish;
  end

  function automatic logic [PIXEL_BITS-1:0] rand_pixel();
    case ($urandom_range(0, 7))
      0:       return 16'h7FFF;
      1:       return 16'h8000;
      2:       return '0;
      3:       return '1;
      default: return PIXEL_BITS'($urandom);
    endcase
  endfunction

  // sender works in bursts; a new burst may start after an idle gap
  task automatic send_pixel(input logic [PIXEL_BITS-1:0] v);
    int   gap;
    logic took;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 9);
      if (gap != 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(30, 60) : $urandom_range(1, 12);
    end
    in_valid <= 1'b1;
    pixel_in <= v;
    // stall is stable by the falling edge
    do begin
      @(negedge clk);
      took = !in_stall;
      @(posedge clk);
    end while (!took);
    burst_left--;
    sent++;
  endtask

  task automatic quiesce();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    // items with no output may still be in the pipe
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
  endtask

  task automatic set_config(input logic [CFG_DATA_W-1:0] mode, input logic [CFG_DATA_W-1:0] sc,
                            input logic [CFG_DATA_W-1:0] w, input logic [CFG_DATA_W-1:0] h,
                            input logic [CFG_DATA_W-1:0] ch);
    quiesce();
    write_reg(REG_MODE, mode);
    write_reg(REG_SCALE, sc);
    write_reg(REG_WIDTH, w);
    write_reg(REG_HEIGHT, h);
    write_reg(REG_CHANNELS, ch);
    cfg_we <= 1'b0;
    settings++;
  endtask

  task automatic pick_dim(input int common_hi, input int clamp_hi,
                          output logic [CFG_DATA_W-1:0] raw, output int eff);
    case ($urandom_range(0, 24))
      0: begin
        raw = '0;
        eff = 1;
      end
      1: begin
        raw = CFG_DATA_W'($urandom_range(clamp_hi + 1, CFG_MAX));
        eff = clamp_hi;
      end
      default: begin
        eff = $urandom_range(1, common_hi);
        raw = CFG_DATA_W'(eff);
      end
    endcase
  endtask

  initial begin
    logic [CFG_DATA_W-1:0] sc_raw;
    logic [CFG_DATA_W-1:0] w_raw;
    logic [CFG_DATA_W-1:0] h_raw;
    logic [CFG_DATA_W-1:0] ch_raw;
    int                    w_eff;
    int                    h_eff;
    int                    ch_eff;
    int                    n;
    int                    base;

    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // reset settings: nearest, scale 2, wide plane
    send_pixel(16'h7FFF);
    send_pixel(16'h8000);
    send_pixel(16'h0000);

    // writes past the register list change nothing, stream goes on at col 3
    quiesce();
    write_reg(REG_SPARE, CFG_DATA_W'($urandom));
    write_reg(REG_SPARE_TOP, CFG_DATA_W'($urandom));
    cfg_we <= 1'b0;
    send_pixel(16'hFFFF);

    // one-cell plane in bilinear mode
    set_config(1, 1, 1, 1, 1);
    send_pixel(16'h0100);

    // 2x2 planes at scale 4: last cell closes four blocks
    set_config(1, 4, 2, 2, 2);
    send_pixel(16'h7FFF);
    send_pixel(16'h8000);
    send_pixel(16'h8000);
    send_pixel(16'h7FFF);
    send_pixel(16'h0001);
    send_pixel(16'hFFFF);
    send_pixel(16'h7FFF);
    send_pixel(16'h8001);

    // all-zero registers: scale and dimensions act as one, mode is nearest
    set_config(0, 0, 0, 0, 0);
    send_pixel(16'h8000);
    send_pixel(16'h5A5A);

    // oversized registers clamp; first row of a tall plane gives nothing
    set_config(1, CFG_DATA_W'(SCALE_MAX_RAW), CFG_DATA_W'(CFG_MAX), CFG_DATA_W'(CFG_MAX),
               CFG_DATA_W'(CFG_MAX));
    send_pixel(16'h7FFF);
    send_pixel(16'h1234);

    // widest row that is also the last row
    quiesce();
    write_reg(REG_HEIGHT, 1);
    cfg_we <= 1'b0;
    settings++;
    send_pixel(16'h8000);
    send_pixel(16'h7FFF);
    send_pixel(16'hC3C3);

    base = sent;

    // heavy bilinear plane while the output holds off
    set_config(1, 4, 3, 3, 1);
    hold_req <= 1'b1;
    repeat (9) send_pixel(rand_pixel());

    while (sent - base < RANDOM_PIXELS) begin
      case ($urandom_range(0, 9))
        0:       sc_raw = '0;
        1:       sc_raw = CFG_DATA_W'($urandom_range(MAX_SCALE + 1, SCALE_MAX_RAW));
        default: sc_raw = CFG_DATA_W'($urandom_range(1, MAX_SCALE));
      endcase
      pick_dim(($urandom_range(0, 4) == 0) ? 40 : 6, MAX_WIDTH, w_raw, w_eff);
      pick_dim(5, LIMIT_DIM, h_raw, h_eff);
      pick_dim(3, LIMIT_DIM, ch_raw, ch_eff);
      // mostly whole planes so bilinear reaches the bottom rows
      n = w_eff * h_eff * ch_eff;
      if (n > 48) n = 48;
      if ($urandom_range(0, 3) == 0) n = $urandom_range(1, n);
      if (n > RANDOM_PIXELS - (sent - base)) n = RANDOM_PIXELS - (sent - base);
      set_config(CFG_DATA_W'($urandom_range(0, 1)), sc_raw, w_raw, h_raw, ch_raw);
      repeat (n) send_pixel(rand_pixel());
    end

    quiesce();
    $display("%0d input pixels over %0d register settings, %0d output pixels compared",
             sent, settings, compared);
    $display("both modes, scales 1-4, zero and oversized registers, %0d-cycle output hold-off",
             HOLD_CYCLES);
    if (errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

[image_upsampler_nearest_bilinear_core.f]
rtl/ups_pkg.sv
rtl/ups_ctrl.sv
rtl/ups_datapath.sv
rtl/image_upsampler_nearest_bilinear_core.sv
tb/ups_checker.sv
tb/image_upsampler_nearest_bilinear_core_tb.sv
